// File: rtl/core/movc_pkg.sv
// Package for the mesh orphan vertex compaction block.
// Holds sizes, field widths and operation codes; depends on nothing.
`default_nettype none

package movc_pkg;

    localparam int MAX_VERTICES = 65536;
    // Corner indices are 16 bits, so the map never needs more than 64K entries.
    localparam int MEM_DEPTH    = (MAX_VERTICES < 65536) ? MAX_VERTICES : 65536;
    localparam int ADDR_W       = $clog2(MEM_DEPTH);

    localparam int IDX_W   = 16;
    localparam int COUNT_W = 17;
    // Map entry: {used, new_index}
    localparam int ENTRY_W = IDX_W + 1;

    typedef logic [1:0]         op_t;
    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [ENTRY_W-1:0] entry_t;

    localparam op_t OP_MARK  = 2'd0;
    localparam op_t OP_RENUM = 2'd1;
    localparam op_t OP_REMAP = 2'd2;
    localparam op_t OP_CLEAR = 2'd3;

endpackage

`default_nettype wire

// File: rtl/core/movc_ram.sv
// Generic single-port synchronous RAM, one access per cycle.
// Registered read data; no dependencies.
`default_nettype none

module movc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/core/mesh_orphan_vertex_compaction.sv
// Top level of the mesh orphan vertex compaction block.
// Sequencer around one map RAM (movc_ram); uses movc_pkg.
//
// Usage:
//   Input channel (in_valid/in_stall) carries op and three corners; output
//   channel (out_valid/out_stall) returns exactly one result per transfer.
//   cfg_we/cfg_data write vertex_count; write it only while the block is idle.
//   Per-vertex state sits in one single-port RAM entry per vertex: {used, new index}.
//   Every access uses the one RAM port, so items run one at a time:
//     mark     three corner writes, each only if the corner is in range
//     renumber read, then write back the same entry if used; no access if exhausted
//     remap    three reads, pipelined one step behind
//     clear    a sweep that writes every entry
//   out_valid rises as the block returns to idle.
//   Reset: a sweep over all MEM_DEPTH entries (65536 as built) clears the map; in_stall
//   stays high meanwhile, config writes are taken as ever.
//   Results wait in an output register. The next item is accepted while a
//   result is stalled; its own result then waits until the register frees.
`default_nettype none

module mesh_orphan_vertex_compaction (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire movc_pkg::count_t        cfg_data,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire movc_pkg::op_t           op,
    input  wire movc_pkg::idx_t          corner_a,
    input  wire movc_pkg::idx_t          corner_b,
    input  wire movc_pkg::idx_t          corner_c,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output movc_pkg::op_t                op_done,
    output movc_pkg::idx_t               vertex_at,
    output logic                         keep,
    output movc_pkg::idx_t               new_a,
    output movc_pkg::idx_t               new_b,
    output movc_pkg::idx_t               new_c,
    output movc_pkg::count_t             kept_total,
    output logic                         fault
);

    import movc_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MARK  = 3'd2;
    localparam logic [2:0] S_RN_RD = 3'd3;
    localparam logic [2:0] S_RN_WR = 3'd4;
    localparam logic [2:0] S_RM    = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    localparam count_t DEPTH_CAP = COUNT_W'(MEM_DEPTH);
    localparam addr_t  LAST_ADDR = ADDR_W'(MEM_DEPTH - 1);

    // control state
    logic [2:0] state_reg, state_next;
    logic [1:0] step_reg, step_next;
    addr_t      sweep_reg, sweep_next;
    logic       clr_op_reg, clr_op_next;
    logic       ok_pend_reg, ok_pend_next;
    count_t     cursor_reg, cursor_next;
    count_t     kept_reg, kept_next;
    count_t     vcount_reg;
    logic       out_valid_reg, out_valid_next;

    // item and result payload
    op_t        op_reg, op_next;
    idx_t       corner_reg [3];
    idx_t       res_at_reg, res_at_next;
    logic       res_keep_reg, res_keep_next;
    idx_t       res_new_reg [3];
    idx_t       res_new_next [3];
    logic       res_fault_reg, res_fault_next;

    op_t        out_op_reg;
    idx_t       out_at_reg;
    logic       out_keep_reg;
    idx_t       out_new_reg [3];
    count_t     out_kept_reg;
    logic       out_fault_reg;

    // RAM port
    logic       mem_we;
    addr_t      mem_addr;
    entry_t     mem_wdata;
    entry_t     mem_rdata;

    count_t     lim;
    idx_t       cur_corner;
    count_t     cur_ext;
    logic       accept;
    logic       out_load;

    movc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MEM_DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign lim      = (vcount_reg > DEPTH_CAP) ? DEPTH_CAP : vcount_reg;
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_load = (state_reg == S_FIN) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        unique case (step_reg)
            2'd0:    cur_corner = corner_reg[0];
            2'd1:    cur_corner = corner_reg[1];
            2'd2:    cur_corner = corner_reg[2];
            default: cur_corner = '0;
        endcase
    end

    assign cur_ext = {1'b0, cur_corner};

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        sweep_next     = sweep_reg;
        clr_op_next    = clr_op_reg;
        ok_pend_next   = ok_pend_reg;
        cursor_next    = cursor_reg;
        kept_next      = kept_reg;
        op_next        = op_reg;
        res_at_next    = res_at_reg;
        res_keep_next  = res_keep_reg;
        res_new_next   = res_new_reg;
        res_fault_next = res_fault_reg;
        mem_we         = 1'b0;
        mem_addr       = cursor_reg[ADDR_W-1:0];
        mem_wdata      = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we     = 1'b1;
                mem_addr   = sweep_reg;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == LAST_ADDR)
                begin
                    state_next = clr_op_reg ? S_FIN : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next        = op;
                    step_next      = 2'd0;
                    res_at_next    = '0;
                    res_keep_next  = 1'b0;
                    res_new_next   = '{default: '0};
                    res_fault_next = 1'b0;
                    unique case (op)
                        OP_MARK:  state_next = S_MARK;
                        OP_RENUM:
                        begin
                            if (cursor_reg < lim)
                            begin
                                state_next = S_RN_RD;
                            end
                            else
                            begin
                                res_fault_next = 1'b1;
                                state_next     = S_FIN;
                            end
                        end
                        OP_REMAP: state_next = S_RM;
                        OP_CLEAR:
                        begin
                            cursor_next = '0;
                            kept_next   = '0;
                            sweep_next  = '0;
                            clr_op_next = 1'b1;
                            state_next  = S_CLEAR;
                        end
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_MARK:
            begin
                mem_addr  = cur_corner[ADDR_W-1:0];
                mem_wdata = {1'b1, {IDX_W{1'b0}}};
                if (cur_ext < lim && cur_ext >= cursor_reg)
                begin
                    mem_we = 1'b1;
                end
                else
                begin
                    res_fault_next = 1'b1;
                end
                step_next = step_reg + 1'b1;
                if (step_reg == 2'd2)
                begin
                    state_next = S_FIN;
                end
            end
            S_RN_RD:
            begin
                state_next = S_RN_WR;
            end
            S_RN_WR:
            begin
                // same entry as the read just before; nothing else touches it
                res_at_next   = cursor_reg[IDX_W-1:0];
                res_keep_next = mem_rdata[ENTRY_W-1];
                if (mem_rdata[ENTRY_W-1])
                begin
                    mem_we          = 1'b1;
                    mem_wdata       = {1'b1, kept_reg[IDX_W-1:0]};
                    res_new_next[0] = kept_reg[IDX_W-1:0];
                    kept_next       = kept_reg + 1'b1;
                end
                cursor_next = cursor_reg + 1'b1;
                state_next  = S_FIN;
            end
            S_RM:
            begin
                // read corner step, capture data for corner step-1
                if (step_reg != 2'd3)
                begin
                    mem_addr     = cur_corner[ADDR_W-1:0];
                    ok_pend_next = (cur_ext < lim) && (cur_ext < cursor_reg);
                end
                if (step_reg != 2'd0)
                begin
                    if (!(ok_pend_reg && mem_rdata[ENTRY_W-1]))
                    begin
                        res_fault_next = 1'b1;
                    end
                    unique case (step_reg)
                        2'd1:
                            res_new_next[0] = ok_pend_reg && mem_rdata[ENTRY_W-1] ?
                                              mem_rdata[IDX_W-1:0] : '0;
                        2'd2:
                            res_new_next[1] = ok_pend_reg && mem_rdata[ENTRY_W-1] ?
                                              mem_rdata[IDX_W-1:0] : '0;
                        default:
                            res_new_next[2] = ok_pend_reg && mem_rdata[ENTRY_W-1] ?
                                              mem_rdata[IDX_W-1:0] : '0;
                    endcase
                end
                step_next = step_reg + 1'b1;
                if (step_reg == 2'd3)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_load)
                begin
                    clr_op_next = 1'b0;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            step_reg      <= '0;
            sweep_reg     <= '0;
            clr_op_reg    <= 1'b0;
            ok_pend_reg   <= 1'b0;
            cursor_reg    <= '0;
            kept_reg      <= '0;
            vcount_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            sweep_reg     <= sweep_next;
            clr_op_reg    <= clr_op_next;
            ok_pend_reg   <= ok_pend_next;
            cursor_reg    <= cursor_next;
            kept_reg      <= kept_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                vcount_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        res_at_reg    <= res_at_next;
        res_keep_reg  <= res_keep_next;
        res_new_reg   <= res_new_next;
        res_fault_reg <= res_fault_next;
        if (accept)
        begin
            corner_reg[0] <= corner_a;
            corner_reg[1] <= corner_b;
            corner_reg[2] <= corner_c;
        end
        if (out_load)
        begin
            out_op_reg    <= op_reg;
            out_at_reg    <= res_at_reg;
            out_keep_reg  <= res_keep_reg;
            out_new_reg   <= res_new_reg;
            out_kept_reg  <= kept_reg;
            out_fault_reg <= res_fault_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign op_done    = out_op_reg;
    assign vertex_at  = out_at_reg;
    assign keep       = out_keep_reg;
    assign new_a      = out_new_reg[0];
    assign new_b      = out_new_reg[1];
    assign new_c      = out_new_reg[2];
    assign kept_total = out_kept_reg;
    assign fault      = out_fault_reg;

`ifndef NO_ASSERTIONS
    a_kept_le_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        kept_reg <= cursor_reg)
        else $error("kept count ran ahead of the cursor");

    a_cursor_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= DEPTH_CAP)
        else $error("cursor beyond map depth");

    a_remap_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RM || state_reg == S_RN_RD) |-> !mem_we)
        else $error("map write during a read phase");

    a_renum_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RN_WR) |=> (cursor_reg == $past(cursor_reg) + 1'b1))
        else $error("renumber did not advance the cursor");
`endif

endmodule

`default_nettype wire
